>>> sv/depth_preferred_transposition_table_core_defines.svh
// Assertion macros for the transposition table core.
// Included by RTL files that carry concurrent checks; depends on nothing.
`ifndef DEPTH_PREFERRED_TRANSPOSITION_TABLE_CORE_DEFINES_SVH
`define DEPTH_PREFERRED_TRANSPOSITION_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dptt check failed");

// Next-cycle implication, disabled during reset.
`define DPTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dptt check failed");

`endif

>>> sv/dptt_pkg.sv
// Types and constants shared by the transposition table core.
// Depends on nothing.
`default_nettype none

package dptt_pkg;

    localparam logic [1:0] FN_LOOKUP = 2'd0;
    localparam logic [1:0] FN_UPDATE = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    localparam logic [28:0] HASH_MUL = 29'h1A85EC53;
    localparam int          HASH_SHIFT = 27;
    localparam int          SUM_W = 47;   // hash bits above 46 never reach the index
    localparam int          IDX_LSB = 23;

    localparam logic signed [31:0] SCORE_MAX_W = 32'sd8388607;
    localparam logic signed [31:0] SCORE_MIN_W = -32'sd8388608;
    localparam logic signed [23:0] SCORE_MAX   = 24'sh7FFFFF;
    localparam logic signed [23:0] SCORE_MIN   = 24'sh800000;
    localparam logic [23:0]        SCORE_BIAS  = 24'h800000;

    typedef struct packed {
        logic [1:0]         func;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [31:0] score;
        logic               suppress_write;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [23:0] score_out;
        logic               written;
    } t_out_item;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_READ,
        ST_RMW
    } t_state;

endpackage

`default_nettype wire

>>> sv/dptt_hash.sv
// Slot index and tag generator: split multiply, then registered sum.
// Depends on dptt_pkg.
`default_nettype none

module dptt_hash
    import dptt_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire logic [63:0]           i_key,
    output logic      [INDEX_BITS-1:0] o_index,
    output logic      [31:0]           o_tag
);

    logic [SUM_W-1:0]      x;
    logic [52:0]           r_p0;
    logic [51:0]           r_p1;
    logic [SUM_W-1:0]      r_key;
    logic [31:0]           r_tag;
    logic [SUM_W-1:0]      sum;
    logic [INDEX_BITS-1:0] r_index;

    assign x = i_key[SUM_W-1:0] ^ {{(SUM_W-(64-HASH_SHIFT)){1'b0}}, i_key[63:HASH_SHIFT]};

    // Two partial products, each under 32 bits wide on the operand side.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p0  <= {29'd0, x[23:0]} * {24'd0, HASH_MUL};
            r_p1  <= {29'd0, x[SUM_W-1:24]} * {23'd0, HASH_MUL};
            r_key <= i_key[SUM_W-1:0];
            r_tag <= i_key[31:0] + i_key[63:32];
        end
    end

    assign sum = r_p0[SUM_W-1:0] + {r_p1[SUM_W-25:0], 24'd0} + r_key;

    always_ff @(posedge i_clk) begin
        r_index <= sum[IDX_LSB +: INDEX_BITS];
    end

    assign o_index = r_index;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

>>> sv/dptt_mem.sv
// Single-port table memory with registered read.
// Depends on dptt_pkg.
`default_nettype none

module dptt_mem
    import dptt_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire t_mem_ctl              i_ctl,
    input  wire logic [INDEX_BITS-1:0] i_addr,
    input  wire logic [63:0]           i_wdata,
    output logic      [63:0]           o_rdata
);

    logic [63:0] r_mem [2**INDEX_BITS];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/depth_preferred_transposition_table_core.sv
// Top level of the depth-preferred transposition table: sequencer and result register.
// Depends on dptt_pkg, dptt_hash, dptt_mem and the assertion macro header.
//
//   channel   direction   valid          ready          payload
//   input     in          i_in_valid     o_in_ready     i_in_data  (t_in_item)
//   output    out         o_out_valid    i_out_ready    o_out_data (t_out_item)
//
// Lookup, update and unused codes step through accept, hash sum, memory read and
// read-modify-write; the single memory port serializes items, so no forwarding is needed.
// Clear sweeps the memory one entry a cycle, then gives its beat.
// After reset the same sweep runs with no beat; input is held off.
// A new item is taken while a result beat waits; the write-back stalls until the slot frees.
`default_nettype none
`include "depth_preferred_transposition_table_core_defines.svh"

module depth_preferred_transposition_table_core
    import dptt_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_state                r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_idx, n_clr_idx;
    logic                  r_clr_reply, n_clr_reply;
    logic                  r_out_valid, n_out_valid;
    t_in_item              r_in;
    t_out_item             r_out;

    logic                  in_accept;
    logic                  out_load;
    t_mem_ctl              mem_ctl;
    logic [INDEX_BITS-1:0] mem_addr;
    logic [63:0]           mem_wdata;
    logic [63:0]           rdata;
    logic [INDEX_BITS-1:0] index;
    logic [31:0]           tag;

    logic                  ent_nz;
    logic                  tag_eq;
    logic                  deep_enough;
    logic                  upd_write;
    logic signed [23:0]    sat_score;
    logic [63:0]           wr_entry;
    t_out_item             result;

    assign in_accept = i_in_valid && o_in_ready;

    dptt_hash #(
        .INDEX_BITS(INDEX_BITS)
    ) u_hash (
        .i_clk  (i_clk),
        .i_load (in_accept),
        .i_key  (i_in_data.key),
        .o_index(index),
        .o_tag  (tag)
    );

    dptt_mem #(
        .INDEX_BITS(INDEX_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(rdata)
    );

    // Entry compare and replacement rule.
    always_comb begin
        ent_nz      = (rdata != 64'd0);
        tag_eq      = (rdata[63:32] == tag);
        deep_enough = (rdata[7:0] >= r_in.depth);
        upd_write   = (r_in.func == FN_UPDATE) && !r_in.suppress_write &&
                      (!ent_nz || !tag_eq || (r_in.depth >= rdata[7:0]));

        if (r_in.score > SCORE_MAX_W) begin
            sat_score = SCORE_MAX;
        end else if (r_in.score < SCORE_MIN_W) begin
            sat_score = SCORE_MIN;
        end else begin
            sat_score = r_in.score[23:0];
        end
        wr_entry = {tag, 24'(sat_score) ^ SCORE_BIAS, r_in.depth};

        result = '0;
        if (r_in.func == FN_LOOKUP && ent_nz && tag_eq && deep_enough) begin
            result.hit       = 1'b1;
            result.score_out = rdata[31:8] ^ SCORE_BIAS;
        end
        result.written = upd_write;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_clr_reply = r_clr_reply;
        o_in_ready  = 1'b0;
        out_load    = 1'b0;
        mem_ctl     = '0;
        mem_addr    = index;
        mem_wdata   = wr_entry;

        case (r_state)
            ST_CLEAR: begin
                mem_ctl.wr_en = 1'b1;
                mem_addr      = r_clr_idx;
                mem_wdata     = 64'd0;
                n_clr_idx     = r_clr_idx + 1'b1;
                if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                    n_state = r_clr_reply ? ST_RMW : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_data.func == FN_CLEAR) begin
                        n_state     = ST_CLEAR;
                        n_clr_idx   = '0;
                        n_clr_reply = 1'b1;
                    end else begin
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                mem_ctl.rd_en = 1'b1;
                n_state       = ST_RMW;
            end
            ST_RMW: begin
                // hold until the result slot is free
                if (!r_out_valid || i_out_ready) begin
                    out_load      = 1'b1;
                    mem_ctl.wr_en = upd_write;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `DPTT_ASSERT_NXT(a_lookup_enters_hash, i_clk, i_rst_n, in_accept && (i_in_data.func != FN_CLEAR), r_state == ST_SUM)
    `DPTT_ASSERT_IMP(a_write_only_on_update, i_clk, i_rst_n, mem_ctl.wr_en && (r_state != ST_CLEAR), (r_in.func == FN_UPDATE) && !r_in.suppress_write)
    `DPTT_ASSERT_IMP(a_hit_excludes_write, i_clk, i_rst_n, r_out_valid, !(r_out.hit && r_out.written))
    `DPTT_ASSERT_NXT(a_rmw_holds_on_stall, i_clk, i_rst_n, (r_state == ST_RMW) && r_out_valid && !i_out_ready, r_state == ST_RMW)

endmodule

`default_nettype wire
